@@ rtl/acpd_pkg.sv @@
// shared types and constants for the audio clock pi discipline block
`timescale 1ns / 1ps
package acpd_pkg;

	// scratch width of the serial datapath
	localparam int WW     = 192;
	localparam int CNT_W  = $clog2(WW);
	// divisor width: 1e9 times the largest sample rate
	localparam int DIV_W  = 50;

	localparam logic [31:0] ONE_Q30     = 32'h4000_0000;
	localparam logic [29:0] NS_PER_S    = 30'd1000000000;
	localparam logic [46:0] ERR_MAX     = 47'h7FFF_FFFF_FFFF;
	localparam logic [19:0] RATE_RESET  = 20'd48000;
	localparam logic [63:0] SIGN64      = 64'h8000_0000_0000_0000;

	// request codes
	localparam logic [1:0] REQ_START    = 2'd0;
	localparam logic [1:0] REQ_STOP     = 2'd1;
	localparam logic [1:0] REQ_CALLBACK = 2'd2;
	localparam logic [1:0] REQ_QUERY    = 2'd3;

	// register indexes
	localparam logic [1:0] REG_RATE     = 2'd0;
	localparam logic [1:0] REG_PGAIN    = 2'd1;
	localparam logic [1:0] REG_IGAIN    = 2'd2;
	localparam logic [1:0] REG_MAXDEV   = 2'd3;

	typedef struct packed {
		logic [19:0] sample_rate_hz;
		logic [31:0] prop_gain;
		logic [31:0] integ_gain;
		logic [29:0] max_gamma_dev;
	} cfg_t;

	typedef struct packed {
		logic        running;
		logic [31:0] ratio;
	} stat_t;

	typedef struct packed {
		logic          neg;
		logic [WW-1:0] mag;
	} sadd_t;

endpackage

@@ rtl/acpd_cfg.sv @@
// configuration register file behind the apb-style port
`timescale 1ns / 1ps
module acpd_cfg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [3:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output acpd_pkg::cfg_t       cfg
);
	import acpd_pkg::*;

	cfg_t cfg_q;
	logic wr_en;

	assign wr_en = psel && penable && pwrite;
	assign cfg   = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_rate_hz <= RATE_RESET;
			cfg_q.prop_gain      <= '0;
			cfg_q.integ_gain     <= '0;
			cfg_q.max_gamma_dev  <= '0;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_RATE:   cfg_q.sample_rate_hz <= pwdata[19:0];
				REG_PGAIN:  cfg_q.prop_gain      <= pwdata;
				REG_IGAIN:  cfg_q.integ_gain     <= pwdata;
				REG_MAXDEV: cfg_q.max_gamma_dev  <= pwdata[29:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (paddr[3:2])
			REG_RATE:   prdata = {12'b0, cfg_q.sample_rate_hz};
			REG_PGAIN:  prdata = cfg_q.prop_gain;
			REG_IGAIN:  prdata = cfg_q.integ_gain;
			REG_MAXDEV: prdata = {2'b0, cfg_q.max_gamma_dev};
			default:    prdata = '0;
		endcase
	end

endmodule

@@ rtl/acpd_engine.sv @@
// sequencer and bit-serial multiply/divide datapath of the pi loop
`timescale 1ns / 1ps
module acpd_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  acpd_pkg::cfg_t      cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          req_type,
	input  logic [63:0]         host_time_ns,
	input  logic signed [63:0]  sample_position,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [63:0]  position,
	output logic [31:0]         rate_ratio,
	output logic                is_running,
	output acpd_pkg::stat_t     stat
);
	import acpd_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE, ST_Q_MSR, ST_Q_RSET, ST_Q_MRAT, ST_Q_DSET, ST_Q_DIV, ST_Q_ADD,
		ST_C_XMUL, ST_C_YSET, ST_C_YMRAT, ST_C_SSET, ST_C_YMSR, ST_C_COMB,
		ST_C_DIV, ST_C_INTEG, ST_C_PMUL, ST_C_QSET, ST_C_QMUL, ST_C_DEV, ST_OUT
	} state_t;

	localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(31);
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(WW - 1);
	localparam logic signed [49:0] ONE_Q40 = 50'sd1 <<< 40;

	function automatic sadd_t sadd(logic [WW-1:0] a, logic na, logic [WW-1:0] b,
			logic nb);
		sadd_t r;
		if (na == nb) begin
			r.mag = a + b;
			r.neg = na;
		end else if (a >= b) begin
			r.mag = a - b;
			r.neg = na;
		end else begin
			r.mag = b - a;
			r.neg = nb;
		end
		return r;
	endfunction

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [WW-1:0]      acc_q;
	logic [WW-1:0]      aux_q;
	logic [WW-1:0]      save_q;
	logic [31:0]        mplier_q;
	logic [DIV_W-1:0]   rem_q;
	logic [DIV_W-1:0]   div_q;
	logic               running_q;
	logic [63:0]        anchor_time_q;
	logic [63:0]        anchor_pos_q;
	logic [31:0]        ratio_q;
	logic signed [47:0] esum_q;
	logic [63:0]        now_q;
	logic [63:0]        hw_q;
	logic [63:0]        elapsed_q;
	logic               xneg_q;
	logic               pneg_q;
	logic               sign_q;
	logic               proj_q;
	logic [63:0]        res_q;
	logic               out_valid_q;
	logic [63:0]        position_q;
	logic [31:0]        rate_ratio_q;
	logic               is_running_q;

	logic               accept;
	logic [63:0]        elapsed_in;
	logic               hw_ge;
	logic [63:0]        dmag;
	logic [DIV_W-1:0]   rate_ns;
	logic [WW-1:0]      mul_add;
	logic [DIV_W:0]     trial;
	logic [DIV_W:0]     trial_diff;
	logic               trial_ge;
	logic [DIV_W-1:0]   rem_next;
	sadd_t              comb_x;
	sadd_t              comb_pq;
	logic [46:0]        emag;
	logic signed [49:0] err_v;
	logic signed [49:0] isum;
	logic signed [49:0] isum_c;
	logic [47:0]        esum_abs;
	logic [WW-1:0]      dev_wide;
	logic [29:0]        dev;
	logic [63:0]        delta;
	logic [64:0]        psum;
	logic [63:0]        proj_pos;

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign out_valid  = out_valid_q;
	assign position   = $signed(position_q);
	assign rate_ratio = rate_ratio_q;
	assign is_running = is_running_q;
	assign stat.running = running_q;
	assign stat.ratio   = ratio_q;

	// elapsed time and position difference at accept
	assign elapsed_in = (host_time_ns > anchor_time_q) ? host_time_ns - anchor_time_q : '0;
	assign hw_ge      = sample_position >= $signed(anchor_pos_q);
	assign dmag       = hw_ge ? 64'(sample_position) - anchor_pos_q
	                          : anchor_pos_q - 64'(sample_position);
	assign rate_ns    = cfg.sample_rate_hz * NS_PER_S;

	// shift-add multiply step, one multiplier bit per cycle
	assign mul_add = mplier_q[0] ? acc_q + aux_q : acc_q;

	// restoring divide step, one quotient bit per cycle
	assign trial      = {rem_q, acc_q[WW-1]};
	assign trial_ge   = trial >= {1'b0, div_q};
	assign trial_diff = trial - {1'b0, div_q};
	assign rem_next   = trial_ge ? trial_diff[DIV_W-1:0] : trial[DIV_W-1:0];

	// sign-magnitude combines
	assign comb_x  = sadd(save_q, xneg_q, acc_q, 1'b1);
	assign comb_pq = sadd(save_q, pneg_q, acc_q, esum_q[47]);

	// error saturation and integrator clamp
	assign emag   = (|acc_q[WW-1:47]) ? ERR_MAX : acc_q[46:0];
	assign err_v  = sign_q ? -$signed({3'b0, emag}) : $signed({3'b0, emag});
	assign isum   = 50'(esum_q) + err_v;
	always_comb begin
		if (isum > ONE_Q40)
			isum_c = ONE_Q40;
		else if (isum < -ONE_Q40)
			isum_c = -ONE_Q40;
		else
			isum_c = isum;
	end
	assign esum_abs = esum_q[47] ? 48'(-esum_q) : 48'(esum_q);

	// gamma deviation clamp
	assign dev_wide = comb_pq.mag >> 26;
	always_comb begin
		if ((|dev_wide[WW-1:30]) || (dev_wide[29:0] > cfg.max_gamma_dev))
			dev = cfg.max_gamma_dev;
		else
			dev = dev_wide[29:0];
	end

	// saturating projected position
	assign delta    = (|acc_q[WW-1:64]) ? '1 : acc_q[63:0];
	assign psum     = {1'b0, anchor_pos_q ^ SIGN64} + {1'b0, delta};
	assign proj_pos = (psum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : psum[63:0]) ^ SIGN64;

	// sequencer, loop state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cnt_q         <= '0;
			acc_q         <= '0;
			aux_q         <= '0;
			save_q        <= '0;
			mplier_q      <= '0;
			rem_q         <= '0;
			div_q         <= '0;
			running_q     <= 1'b0;
			anchor_time_q <= '0;
			anchor_pos_q  <= '0;
			ratio_q       <= ONE_Q30;
			esum_q        <= '0;
			now_q         <= '0;
			hw_q          <= '0;
			elapsed_q     <= '0;
			xneg_q        <= 1'b0;
			pneg_q        <= 1'b0;
			sign_q        <= 1'b0;
			proj_q        <= 1'b0;
			res_q         <= '0;
			out_valid_q   <= 1'b0;
			position_q    <= '0;
			rate_ratio_q  <= ONE_Q30;
			is_running_q  <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && (state_q != ST_OUT))
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						proj_q  <= 1'b0;
						state_q <= ST_OUT;
						case (req_type)
							REQ_START: begin
								anchor_time_q <= host_time_ns;
								anchor_pos_q  <= 64'(sample_position);
								ratio_q       <= ONE_Q30;
								esum_q        <= '0;
								running_q     <= 1'b1;
							end
							REQ_STOP: begin
								running_q <= 1'b0;
							end
							REQ_CALLBACK: begin
								if (running_q && (cfg.sample_rate_hz != '0)) begin
									now_q     <= host_time_ns;
									hw_q      <= 64'(sample_position);
									elapsed_q <= elapsed_in;
									xneg_q    <= !hw_ge;
									div_q     <= rate_ns;
									aux_q     <= WW'(dmag) << 40;
									acc_q     <= '0;
									mplier_q  <= {2'b0, NS_PER_S};
									cnt_q     <= '0;
									state_q   <= ST_C_XMUL;
								end
							end
							REQ_QUERY: begin
								if (running_q) begin
									proj_q    <= 1'b1;
									elapsed_q <= elapsed_in;
									div_q     <= DIV_W'(NS_PER_S);
									aux_q     <= WW'(elapsed_in);
									acc_q     <= '0;
									mplier_q  <= {12'b0, cfg.sample_rate_hz};
									cnt_q     <= '0;
									state_q   <= ST_Q_MSR;
								end
							end
							default: ;
						endcase
					end
				end

				// multiply steps shared by every product
				ST_Q_MSR, ST_Q_MRAT, ST_C_XMUL, ST_C_YMRAT, ST_C_YMSR,
				ST_C_PMUL, ST_C_QMUL: begin
					acc_q    <= mul_add;
					aux_q    <= aux_q << 1;
					mplier_q <= mplier_q >> 1;
					cnt_q    <= cnt_q + 1'b1;
					if (cnt_q == MUL_LAST) begin
						case (state_q)
							ST_Q_MSR:   state_q <= ST_Q_RSET;
							ST_Q_MRAT:  state_q <= ST_Q_DSET;
							ST_C_XMUL:  state_q <= ST_C_YSET;
							ST_C_YMRAT: state_q <= ST_C_SSET;
							ST_C_YMSR:  state_q <= ST_C_COMB;
							ST_C_PMUL:  state_q <= ST_C_QSET;
							default:    state_q <= ST_C_DEV;
						endcase
					end
				end

				// divide steps
				ST_Q_DIV, ST_C_DIV: begin
					rem_q <= rem_next;
					acc_q <= {acc_q[WW-2:0], trial_ge};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIV_LAST)
						state_q <= (state_q == ST_Q_DIV) ? ST_Q_ADD : ST_C_INTEG;
				end

				ST_Q_RSET: begin
					aux_q    <= acc_q;
					acc_q    <= '0;
					mplier_q <= ratio_q;
					cnt_q    <= '0;
					state_q  <= ST_Q_MRAT;
				end

				ST_Q_DSET: begin
					acc_q   <= acc_q >> 30;
					rem_q   <= '0;
					cnt_q   <= '0;
					state_q <= ST_Q_DIV;
				end

				ST_Q_ADD: begin
					res_q   <= proj_pos;
					state_q <= ST_OUT;
				end

				ST_C_YSET: begin
					save_q   <= acc_q;
					aux_q    <= WW'(elapsed_q);
					acc_q    <= '0;
					mplier_q <= ratio_q;
					cnt_q    <= '0;
					state_q  <= ST_C_YMRAT;
				end

				ST_C_SSET: begin
					aux_q    <= acc_q << 10;
					acc_q    <= '0;
					mplier_q <= {12'b0, cfg.sample_rate_hz};
					cnt_q    <= '0;
					state_q  <= ST_C_YMSR;
				end

				// error numerator: position term minus elapsed term
				ST_C_COMB: begin
					acc_q   <= comb_x.mag;
					sign_q  <= comb_x.neg;
					rem_q   <= '0;
					cnt_q   <= '0;
					state_q <= ST_C_DIV;
				end

				ST_C_INTEG: begin
					esum_q   <= 48'(isum_c);
					pneg_q   <= sign_q && (emag != '0);
					aux_q    <= WW'(emag);
					acc_q    <= '0;
					mplier_q <= cfg.prop_gain;
					cnt_q    <= '0;
					state_q  <= ST_C_PMUL;
				end

				ST_C_QSET: begin
					save_q   <= acc_q;
					aux_q    <= WW'(esum_abs);
					acc_q    <= '0;
					mplier_q <= cfg.integ_gain;
					cnt_q    <= '0;
					state_q  <= ST_C_QMUL;
				end

				// new gamma and re-anchor
				ST_C_DEV: begin
					ratio_q       <= comb_pq.neg ? ONE_Q30 - {2'b0, dev}
					                             : ONE_Q30 + {2'b0, dev};
					anchor_time_q <= now_q;
					anchor_pos_q  <= hw_q;
					state_q       <= ST_OUT;
				end

				ST_OUT: begin
					if (!out_valid_q || out_ready) begin
						position_q   <= proj_q ? res_q : anchor_pos_q;
						rate_ratio_q <= ratio_q;
						is_running_q <= running_q;
						out_valid_q  <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/audio_clock_pi_discipline_core.sv @@
// top level of the audio clock pi discipline block
// start, stop, stopped query and ignored callback pass from accept through the output
// state to the output register; running query and active callback first run the
// 32-step shift-add multiplier and the 192-step restoring divider.
// one item at a time: the next item is accepted once the result is handed to the
// output register. reset clears the loop state, sets gamma to one and rate to 48000.
`timescale 1ns / 1ps
module audio_clock_pi_discipline_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         req_type,
	input  logic [63:0]        host_time_ns,
	input  logic signed [63:0] sample_position,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [63:0] position,
	output logic [31:0]        rate_ratio,
	output logic               is_running
);
	import acpd_pkg::*;

	cfg_t  cfg;
	stat_t stat;

	assign pready = 1'b1;

	// configuration registers
	acpd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// loop engine
	acpd_engine u_engine (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.req_type        (req_type),
		.host_time_ns    (host_time_ns),
		.sample_position (sample_position),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.position        (position),
		.rate_ratio      (rate_ratio),
		.is_running      (is_running),
		.stat            (stat)
	);

	// an accepted item leaves the engine busy in the cycle after accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("engine ready right after accepting an item");

	// stop clears the running flag
	a_stop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (req_type == REQ_STOP) |=> !stat.running)
		else $error("running flag still set after stop");

	// start sets running with unity gamma
	a_start_sets: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (req_type == REQ_START)
		|=> stat.running && (stat.ratio == ONE_Q30))
		else $error("start did not set running with unity gamma");

endmodule
